>>> src/btpe_pkg.sv
`default_nettype none
package btpe_pkg;

  localparam int NODE_W = 9;
  localparam int CNT_W  = 8;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_EMIT  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic ld_first;   // first edge into an empty slot, written at once
    logic ld_read;    // read the slot of a filled entry
    logic ld_write;   // read-modify-write of that slot
    logic em_start;   // pick node, issue table or stack read
    logic em_finish;  // form result word, push or pop
  } btpe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ld_slot_ok;
    logic ld_slot_filled;
    logic em_over;
    logic out_free;
  } btpe_stat_t;

endpackage
`default_nettype wire

>>> src/btpe_ctrl.sv
`default_nettype none
module btpe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_action,
  output logic                    in_ready,
  input  wire btpe_pkg::btpe_stat_t stat,
  output btpe_pkg::btpe_cmd_t     cmd
);
  import btpe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LD_WR,
    S_EM_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (action_t'(in_action))
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_LOAD: begin
              if (stat.ld_slot_ok) begin
                if (stat.ld_slot_filled) begin
                  cmd.ld_read = 1'b1;
                  state_nxt   = S_LD_WR;
                end else begin
                  cmd.ld_first = 1'b1;
                end
              end
            end
            ACT_EMIT: begin
              if (!stat.em_over) begin
                cmd.em_start = 1'b1;
                state_nxt    = S_EM_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_EM_FIN: begin
        if (stat.out_free) begin
          cmd.em_finish = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/btpe_dp.sv
`default_nettype none
module btpe_dp #(
  parameter int MAX_INTERNAL = 255
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [7:0]         cfg_internal_count,
  input  wire logic [8:0]         in_edge_parent,
  input  wire logic [8:0]         in_edge_child,
  input  wire btpe_pkg::btpe_cmd_t cmd,
  output btpe_pkg::btpe_stat_t    stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [8:0]              out_parent,
  output logic [8:0]              out_child,
  output logic                    out_last_edge,
  output logic                    out_error
);
  import btpe_pkg::*;

  localparam int SW = (MAX_INTERNAL > 1) ? $clog2(MAX_INTERNAL) : 1;
  localparam int WW = 2 * NODE_W;

  // config and control state
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [MAX_INTERNAL-1:0] filled_r, filled_nxt;
  logic [CNT_W-1:0]        depth_r, depth_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt;
  logic [NODE_W-1:0]       cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // per-item payload
  logic [NODE_W-1:0] node_r, ld_child_r;
  logic [SW-1:0]     ld_slot_r;
  logic              pop_r, under_r, use_tbl_r;
  logic [NODE_W-1:0] out_parent_r, out_child_r;
  logic              out_last_r, out_err_r;

  // memories: {left, right} and {parent, child}
  logic [WW-1:0] tbl_mem [MAX_INTERNAL];
  logic [WW-1:0] stk_mem [MAX_INTERNAL];
  logic [WW-1:0] tbl_rd_r, stk_rd_r;
  logic          tbl_we, tbl_re, stk_we, stk_re;
  logic [SW-1:0] tbl_waddr, tbl_raddr, stk_waddr, stk_raddr;
  logic [WW-1:0] tbl_wdata, stk_wdata;

  logic [NODE_W-1:0] root, total, node_sel;
  logic [CNT_W-1:0]  cap;
  logic              ld_ok, nd_ok;
  logic [SW-1:0]     ld_slot, nd_slot;
  logic [NODE_W-1:0] l_val, r_val, tl, tr;
  logic              push_full;

  function automatic logic slot_hit(logic [NODE_W-1:0] node, logic [NODE_W-1:0] rt,
                                    logic [CNT_W-1:0] n);
    logic [NODE_W-1:0] idx;
    idx = node - rt;
    return (node >= rt) && (idx < {1'b0, n}) && (32'(idx) < MAX_INTERNAL);
  endfunction

  assign root  = {1'b0, n_r} + NODE_W'(2);
  assign total = {n_r, 1'b0};
  assign cap   = (32'(n_r) < MAX_INTERNAL) ? n_r : CNT_W'(MAX_INTERNAL);

  assign node_sel = (cnt_r == '0) ? root : cur_r;
  assign ld_ok    = slot_hit(in_edge_parent, root, n_r);
  assign nd_ok    = slot_hit(node_sel, root, n_r);
  assign ld_slot  = SW'(in_edge_parent - root);
  assign nd_slot  = SW'(node_sel - root);

  assign stat.ld_slot_ok     = ld_ok;
  assign stat.ld_slot_filled = filled_r[ld_slot];
  assign stat.em_over        = (cnt_r >= total);
  assign stat.out_free       = !out_valid_r || out_ready;

  assign tl        = tbl_rd_r[WW-1:NODE_W];
  assign tr        = tbl_rd_r[NODE_W-1:0];
  assign l_val     = use_tbl_r ? tl : '0;
  assign r_val     = use_tbl_r ? tr : '0;
  assign push_full = (depth_r >= cap);

  always_comb begin
    n_nxt         = cfg_valid ? cfg_internal_count : n_r;
    filled_nxt    = filled_r;
    depth_nxt     = depth_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    tbl_we    = 1'b0;
    tbl_waddr = ld_slot;
    tbl_wdata = {in_edge_child, {NODE_W{1'b0}}};
    tbl_re    = cmd.ld_read || (cmd.em_start && nd_ok && filled_r[nd_slot]);
    tbl_raddr = cmd.ld_read ? ld_slot : nd_slot;
    stk_we    = 1'b0;
    stk_waddr = SW'(depth_r);
    stk_wdata = {node_r, r_val};
    stk_re    = cmd.em_start && (node_sel < root) && (depth_r != '0);
    stk_raddr = SW'(depth_r - CNT_W'(1));

    if (cmd.clear) begin
      filled_nxt = '0;
      depth_nxt  = '0;
      cur_nxt    = '0;
      cnt_nxt    = '0;
    end

    if (cmd.ld_first) begin
      tbl_we              = 1'b1;
      filled_nxt[ld_slot] = 1'b1;
    end

    if (cmd.ld_write) begin
      tbl_we    = 1'b1;
      tbl_waddr = ld_slot_r;
      if ((tl < ld_child_r) && (ld_child_r > root)) begin
        tbl_wdata = {tl, ld_child_r};
      end else begin
        tbl_wdata = {ld_child_r, tl};
      end
    end

    if (cmd.em_finish) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = cnt_r + NODE_W'(1);
      if (pop_r) begin
        if (!under_r) begin
          depth_nxt = depth_r - CNT_W'(1);
          cur_nxt   = stk_rd_r[NODE_W-1:0];
        end
      end else begin
        cur_nxt = l_val;
        if (!push_full) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= CNT_W'(1);
      filled_r    <= '0;
      depth_r     <= '0;
      cur_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      filled_r    <= filled_nxt;
      depth_r     <= depth_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_read) begin
      ld_slot_r  <= ld_slot;
      ld_child_r <= in_edge_child;
    end
    if (cmd.em_start) begin
      node_r    <= node_sel;
      pop_r     <= (node_sel < root);
      under_r   <= (node_sel < root) && (depth_r == '0);
      use_tbl_r <= nd_ok && filled_r[nd_slot];
    end
    if (cmd.em_finish) begin
      out_last_r <= ((cnt_r + NODE_W'(1)) == total);
      if (pop_r) begin
        out_parent_r <= under_r ? '0 : stk_rd_r[WW-1:NODE_W];
        out_child_r  <= under_r ? '0 : stk_rd_r[NODE_W-1:0];
        out_err_r    <= under_r;
      end else begin
        out_parent_r <= node_r;
        out_child_r  <= l_val;
        out_err_r    <= push_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_r <= stk_mem[stk_raddr];
  end

  assign out_valid     = out_valid_r;
  assign out_parent    = out_parent_r;
  assign out_child     = out_child_r;
  assign out_last_edge = out_last_r;
  assign out_error     = out_err_r;

endmodule
`default_nettype wire

>>> src/binary_tree_preorder_edges.sv
// Emit: the word enters the output register in the finish state, after the registered
//   table or stack read and once the output is free; other words give no result.
// Flow: clear, ignored words and first loads stay idle; filled-slot loads (read, then
//   write) and emits add a second state; an emit stalls while the output word waits.
// Reset (sync, active low): N=1, slot-filled bits, stack depth, walk node and edge
//   count cleared; child tables and stack contents are undefined until written.
`default_nettype none
module binary_tree_preorder_edges #(
  parameter int MAX_INTERNAL = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // config write word: internal node count N
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_internal_count,
  // input words
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [8:0] in_edge_parent,
  input  wire logic [8:0] in_edge_child,
  // result words
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [8:0]      out_parent,
  output logic [8:0]      out_child,
  output logic            out_last_edge,
  output logic            out_error
);
  import btpe_pkg::*;

  btpe_cmd_t  cmd;
  btpe_stat_t stat;

  // the user must write the register only while idle (the block itself has no check), so no backpressure needed
  assign cfg_ready = 1'b1;

  // sequencer: idle / load read-modify-write / emit finish
  btpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, slot-filled bits, pending-branch stack, walk state, output register
  btpe_dp #(
    .MAX_INTERNAL (MAX_INTERNAL)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_internal_count (cfg_internal_count),
    .in_edge_parent     (in_edge_parent),
    .in_edge_child      (in_edge_child),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_parent         (out_parent),
    .out_child          (out_child),
    .out_last_edge      (out_last_edge),
    .out_error          (out_error)
  );

`ifndef SYNTHESIS
  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.ld_first, cmd.ld_read, cmd.ld_write,
              cmd.em_start, cmd.em_finish}))
    else $error("controller issued more than one command");

  // a result never overwrites a word still waiting at the output
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_finish |-> stat.out_free)
    else $error("emit finished while output register busy");

  // slot read is always followed by its write
  a_ld_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_read |=> cmd.ld_write)
    else $error("load read not followed by write");

  // no new word taken while an emit is in flight
  a_em_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_start |=> !in_ready)
    else $error("input accepted during emit");
`endif

endmodule
`default_nettype wire
